[rtl/rbn_pkg.sv]
// ============================================================================
// rbn_pkg: shared types and constants of the ray/box nearest hit unit
// Fixed point formats, queue entry and result layouts, end point helper.
// ============================================================================
package rbn_pkg;

    localparam int COORD_BITS = 24;                 // Q15.8 coordinates
    localparam int OWNER_BITS = 16;
    localparam int DIR_BITS   = 16;                 // Q1.14 directions
    localparam int DIR_FRAC   = 14;
    localparam int DIST_BITS  = COORD_BITS - 1;
    localparam int EPS_BITS   = 15;
    localparam int EDGE_BITS  = COORD_BITS + 1;     // box edge incl. far side
    localparam int DIFF_BITS  = COORD_BITS + 2;     // edge minus origin
    localparam int NUM_BITS   = EDGE_BITS + DIR_FRAC;
    localparam int QUO_BITS   = NUM_BITS + 1;       // signed slab distance
    localparam int PROD_BITS  = DIR_BITS + DIST_BITS + 1;
    localparam int CNT_BITS   = $clog2(NUM_BITS + 1);

    localparam int IN_RAW_BITS   = 2 * DIR_BITS + 2 * COORD_BITS + 2 * DIST_BITS
                                 + OWNER_BITS;
    localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS  = 2 * COORD_BITS + OWNER_BITS + DIST_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [1:0] REG_ORIGIN_X     = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y     = 2'd1;
    localparam logic [1:0] REG_MAX_DISTANCE = 2'd2;
    localparam logic [1:0] REG_DIR_EPSILON  = 2'd3;

    localparam logic [EPS_BITS-1:0]  EPS_RESET  = EPS_BITS'(1);
    localparam logic [DIST_BITS-1:0] DIST_RESET = DIST_BITS'(25600);

    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic [DIST_BITS-1:0]         max_distance;
        logic [EPS_BITS-1:0]          dir_epsilon;
    } cfg_t;

    typedef struct packed {
        logic signed [DIR_BITS-1:0]  dir_x;
        logic signed [DIR_BITS-1:0]  dir_y;
        logic signed [EDGE_BITS-1:0] lo_x;
        logic signed [EDGE_BITS-1:0] hi_x;
        logic signed [EDGE_BITS-1:0] lo_y;
        logic signed [EDGE_BITS-1:0] hi_y;
        logic [OWNER_BITS-1:0]       owner;
        logic                        present;
        logic                        last;
    } q_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic                         hit_found;
        logic [OWNER_BITS-1:0]        hit_owner;
        logic [DIST_BITS-1:0]         hit_distance;
    } result_t;

    // origin + prod / 2^DIR_FRAC (toward zero), saturated to a coordinate
    function automatic logic signed [COORD_BITS-1:0] end_coord(
        input logic signed [COORD_BITS-1:0] org,
        input logic signed [PROD_BITS-1:0]  prod
    );
        logic signed [PROD_BITS-1:0]          adj;
        logic signed [PROD_BITS-DIR_FRAC-1:0] q;
        logic signed [PROD_BITS-DIR_FRAC:0]   sum;
        logic signed [PROD_BITS-DIR_FRAC:0]   hi_lim;
        logic signed [PROD_BITS-DIR_FRAC:0]   lo_lim;
        adj    = prod + (prod[PROD_BITS-1] ? PROD_BITS'((1 << DIR_FRAC) - 1)
                                           : PROD_BITS'(0));
        q      = adj[PROD_BITS-1:DIR_FRAC];
        sum    = (PROD_BITS-DIR_FRAC+1)'(org) + (PROD_BITS-DIR_FRAC+1)'(q);
        hi_lim = $signed((PROD_BITS-DIR_FRAC+1)'({(COORD_BITS-1){1'b1}}));
        lo_lim = ~hi_lim;
        if (sum > hi_lim)
            return hi_lim[COORD_BITS-1:0];
        else if (sum < lo_lim)
            return lo_lim[COORD_BITS-1:0];
        else
            return sum[COORD_BITS-1:0];
    endfunction

endpackage

[rtl/rbn_front.sv]
// ============================================================================
// rbn_front: input side of the ray/box nearest hit unit
// Unpacks an input beat, forms the box slab edges and queues the item.
// ============================================================================
module rbn_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [rbn_pkg::IN_DATA_BITS-1:0]   s_tdata,
    input  logic                               s_tlast,
    input  logic                               s_tuser,
    output logic                               q_valid,
    output rbn_pkg::q_item_t                   q_item,
    input  logic                               q_pop
);
    import rbn_pkg::*;

    localparam int OFS_DY = DIR_BITS;
    localparam int OFS_BX = 2 * DIR_BITS;
    localparam int OFS_BY = OFS_BX + COORD_BITS;
    localparam int OFS_BW = OFS_BY + COORD_BITS;
    localparam int OFS_BH = OFS_BW + DIST_BITS;
    localparam int OFS_OW = OFS_BH + DIST_BITS;

    q_item_t     slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    q_item_t     item_in;
    logic        push;

    logic signed [COORD_BITS-1:0] box_x, box_y;
    logic [DIST_BITS-1:0]         box_w, box_h;

    always_comb
    begin
        box_x = s_tdata[OFS_BX +: COORD_BITS];
        box_y = s_tdata[OFS_BY +: COORD_BITS];
        box_w = s_tdata[OFS_BW +: DIST_BITS];
        box_h = s_tdata[OFS_BH +: DIST_BITS];
        item_in.dir_x   = s_tdata[0 +: DIR_BITS];
        item_in.dir_y   = s_tdata[OFS_DY +: DIR_BITS];
        item_in.lo_x    = EDGE_BITS'(box_x);
        item_in.hi_x    = EDGE_BITS'(box_x) + $signed(EDGE_BITS'({1'b0, box_w}));
        item_in.lo_y    = EDGE_BITS'(box_y);
        item_in.hi_y    = EDGE_BITS'(box_y) + $signed(EDGE_BITS'({1'b0, box_h}));
        item_in.owner   = s_tdata[OFS_OW +: OWNER_BITS];
        item_in.present = s_tuser;
        item_in.last    = s_tlast;
    end

    assign s_tready = (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= item_in;
    end

endmodule

[rtl/rbn_div.sv]
// ============================================================================
// rbn_div: serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ============================================================================
module rbn_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [rbn_pkg::NUM_BITS-1:0]   dividend,
    input  logic [rbn_pkg::DIR_BITS-1:0]   divisor,
    output logic                           done,
    output logic [rbn_pkg::NUM_BITS-1:0]   quotient
);
    import rbn_pkg::*;

    logic [NUM_BITS-1:0] quo_reg;
    logic [DIR_BITS-1:0] rem_reg;
    logic [DIR_BITS-1:0] div_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [DIR_BITS:0]   trial;
    logic                fits;

    assign trial    = {rem_reg, quo_reg[NUM_BITS-1]};
    assign fits     = (trial >= {1'b0, div_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_BITS-2:0], fits};
            rem_reg <= fits ? DIR_BITS'(trial - {1'b0, div_reg}) : trial[DIR_BITS-1:0];
        end
    end

endmodule

[rtl/rbn_back.sv]
// ============================================================================
// rbn_back: slab test and ray closing sequencer
// Runs four slab divisions per box, tracks the nearest hit, emits results.
// ============================================================================
module rbn_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rbn_pkg::cfg_t        cfg,
    input  logic                 q_valid,
    input  rbn_pkg::q_item_t     q_item,
    output logic                 q_pop,
    output logic                 res_valid,
    input  logic                 res_ready,
    output rbn_pkg::result_t     res
);
    import rbn_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_MULX  = 3'd4;
    localparam logic [2:0] S_MULY  = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]                  state_reg, state_next;
    q_item_t                     item_reg;
    logic [1:0]                  k_reg;
    logic                        neg_reg;
    logic signed [QUO_BITS-1:0]  t_reg [4];
    logic [DIST_BITS-1:0]        closest_reg;
    logic [OWNER_BITS-1:0]       owner_reg;
    logic                        any_reg;
    logic                        open_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [COORD_BITS-1:0] endx_reg;
    logic                        out_valid_reg;
    result_t                     out_reg;

    // divider operands
    logic signed [EDGE_BITS-1:0] edge_sel;
    logic signed [COORD_BITS-1:0] org_sel;
    logic signed [DIR_BITS-1:0]  dir_sel;
    logic signed [DIFF_BITS-1:0] diff;
    logic [DIFF_BITS-1:0]        diff_abs;
    logic [DIR_BITS-1:0]         dir_abs;
    logic [NUM_BITS-1:0]         dividend;
    logic                        div_start, div_done;
    logic [NUM_BITS-1:0]         quo_mag;
    logic signed [QUO_BITS-1:0]  quo_pos;

    // slab evaluation
    logic [DIR_BITS-1:0]         abs_x, abs_y;
    logic                        par_x, par_y;
    logic signed [EDGE_BITS-1:0] ox, oy;
    logic signed [QUO_BITS-1:0]  tmin, tmax, ta, tb, closest_s;
    logic                        bounded, ok, hit;
    logic                        fin_go;

    always_comb
    begin
        case (k_reg)
            2'd0:    edge_sel = item_reg.lo_x;
            2'd1:    edge_sel = item_reg.hi_x;
            2'd2:    edge_sel = item_reg.lo_y;
            default: edge_sel = item_reg.hi_y;
        endcase
        org_sel  = k_reg[1] ? cfg.origin_y : cfg.origin_x;
        dir_sel  = k_reg[1] ? item_reg.dir_y : item_reg.dir_x;
        diff     = DIFF_BITS'(edge_sel) - DIFF_BITS'(org_sel);
        diff_abs = diff[DIFF_BITS-1] ? DIFF_BITS'(-diff) : DIFF_BITS'(diff);
        dir_abs  = dir_sel[DIR_BITS-1] ? DIR_BITS'(-dir_sel) : DIR_BITS'(dir_sel);
        dividend = {diff_abs[EDGE_BITS-1:0], {DIR_FRAC{1'b0}}};
        quo_pos  = $signed(QUO_BITS'(quo_mag));
    end

    assign div_start = (state_reg == S_START);

    rbn_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (dir_abs),
        .done     (div_done),
        .quotient (quo_mag)
    );

    always_comb
    begin
        abs_x = item_reg.dir_x[DIR_BITS-1] ? DIR_BITS'(-item_reg.dir_x)
                                           : DIR_BITS'(item_reg.dir_x);
        abs_y = item_reg.dir_y[DIR_BITS-1] ? DIR_BITS'(-item_reg.dir_y)
                                           : DIR_BITS'(item_reg.dir_y);
        par_x = (item_reg.dir_x == '0) || (abs_x < DIR_BITS'(cfg.dir_epsilon));
        par_y = (item_reg.dir_y == '0) || (abs_y < DIR_BITS'(cfg.dir_epsilon));
        ox    = EDGE_BITS'(cfg.origin_x);
        oy    = EDGE_BITS'(cfg.origin_y);
        closest_s = $signed(QUO_BITS'(closest_reg));
        tmin    = '0;
        tmax    = '0;
        bounded = 1'b0;
        ok      = 1'b1;
        ta      = '0;
        tb      = '0;
        if (par_x)
            ok = !(ox < item_reg.lo_x || ox > item_reg.hi_x);
        else
        begin
            ta = (t_reg[0] < t_reg[1]) ? t_reg[0] : t_reg[1];
            tb = (t_reg[0] < t_reg[1]) ? t_reg[1] : t_reg[0];
            if (ta > tmin)
                tmin = ta;
            tmax    = tb;
            bounded = 1'b1;
            ok      = (tmin <= tmax);
        end
        if (ok)
        begin
            if (par_y)
                ok = !(oy < item_reg.lo_y || oy > item_reg.hi_y);
            else
            begin
                ta = (t_reg[2] < t_reg[3]) ? t_reg[2] : t_reg[3];
                tb = (t_reg[2] < t_reg[3]) ? t_reg[3] : t_reg[2];
                if (ta > tmin)
                    tmin = ta;
                if (!bounded || tb < tmax)
                    tmax = tb;
                ok = (tmin <= tmax);
            end
        end
        hit = item_reg.present && ok && (tmin > '0) && (tmin < closest_s);
    end

    assign q_pop  = (state_reg == S_IDLE) && q_valid;
    assign fin_go = (state_reg == S_FIN) && (!out_valid_reg || res_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.present)
                        state_next = S_START;
                    else if (q_item.last)
                        state_next = S_MULX;
                end
            end
            S_START: state_next = S_WAIT;
            S_WAIT:
            begin
                if (div_done)
                    state_next = (k_reg == 2'd3) ? S_EVAL : S_START;
            end
            S_EVAL:  state_next = item_reg.last ? S_MULX : S_IDLE;
            S_MULX:  state_next = S_MULY;
            S_MULY:  state_next = S_FIN;
            S_FIN:
            begin
                if (fin_go)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= 2'd0;
            closest_reg   <= DIST_RESET;
            owner_reg     <= '0;
            any_reg       <= 1'b0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                k_reg <= 2'd0;
                // open a new ray
                if (!open_reg)
                begin
                    closest_reg <= cfg.max_distance;
                    owner_reg   <= '0;
                    any_reg     <= 1'b0;
                    open_reg    <= 1'b1;
                end
            end
            if (state_reg == S_WAIT && div_done)
                k_reg <= k_reg + 2'd1;
            if (state_reg == S_EVAL && hit)
            begin
                closest_reg <= tmin[DIST_BITS-1:0];
                owner_reg   <= item_reg.owner;
                any_reg     <= 1'b1;
            end
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
                open_reg      <= 1'b0;
            end
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            item_reg <= q_item;
        if (div_start)
            neg_reg <= diff[DIFF_BITS-1] ^ dir_sel[DIR_BITS-1];
        if (state_reg == S_WAIT && div_done)
            t_reg[k_reg] <= neg_reg ? -quo_pos : quo_pos;
        if (state_reg == S_MULX)
            prod_reg <= PROD_BITS'(item_reg.dir_x)
                      * $signed(PROD_BITS'({1'b0, closest_reg}));
        if (state_reg == S_MULY)
        begin
            endx_reg <= end_coord(cfg.origin_x, prod_reg);
            prod_reg <= PROD_BITS'(item_reg.dir_y)
                      * $signed(PROD_BITS'({1'b0, closest_reg}));
        end
        if (fin_go)
        begin
            out_reg.end_x        <= endx_reg;
            out_reg.end_y        <= end_coord(cfg.origin_y, prod_reg);
            out_reg.hit_found    <= any_reg;
            out_reg.hit_owner    <= owner_reg;
            out_reg.hit_distance <= closest_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    a_no_hit_owner: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.hit_found |-> out_reg.hit_owner == '0)
        else $error("result without hit carries an owner");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_WAIT)
        else $error("divider finished outside the wait state");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result raised without closing a ray");

endmodule

[rtl/ray_box_nearest_hit_unit.sv]
// ============================================================================
// ray_box_nearest_hit_unit: nearest axis-aligned box hit by one 2D ray
// Register block, input queue and slab test sequencer.
// ============================================================================
//  channel  | kind          | content
//  s_*      | stream in     | direction, one box, owner; tlast ends the ray
//  m_*      | stream out    | end point, owner, distance; tuser = hit flag
//  p*       | register port | origin_x, origin_y, max_distance, dir_epsilon
//
// For a box item the serial divider forms the four slab distances one bit a
// cycle. An item without a box needs no division; a closing item adds the end
// point multiplies in S_MULX and S_MULY. A two-entry queue keeps accepting
// while the back works, and a waiting result holds the back only at the ray
// close. Reset clears all control state at once; no clearing pass.
// ============================================================================
module ray_box_nearest_hit_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // dir_x, dir_y, box_x, box_y, box_w, box_h, box_owner (low bit up)
    input  logic [rbn_pkg::IN_DATA_BITS-1:0]     s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic                                 s_tlast,
    // box_present
    input  logic                                 s_tuser,
    // end_x, end_y, hit_owner, hit_distance (low bit up)
    output logic [rbn_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // hit_found
    output logic                                 m_tuser,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [rbn_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [rbn_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [rbn_pkg::CFG_DATA_BITS-1:0]    prdata,
    output logic                                 pready
);
    import rbn_pkg::*;

    cfg_t      cfg_reg;
    logic      cfg_write;
    logic      q_valid, q_pop;
    q_item_t   q_item;
    result_t   res;
    logic      res_valid;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x     <= '0;
            cfg_reg.origin_y     <= '0;
            cfg_reg.max_distance <= DIST_RESET;
            cfg_reg.dir_epsilon  <= EPS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_ORIGIN_X:     cfg_reg.origin_x     <= pwdata[COORD_BITS-1:0];
                REG_ORIGIN_Y:     cfg_reg.origin_y     <= pwdata[COORD_BITS-1:0];
                REG_MAX_DISTANCE: cfg_reg.max_distance <= pwdata[DIST_BITS-1:0];
                REG_DIR_EPSILON:  cfg_reg.dir_epsilon  <= pwdata[EPS_BITS-1:0];
                default:          cfg_reg.dir_epsilon  <= cfg_reg.dir_epsilon;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ORIGIN_X:     prdata = CFG_DATA_BITS'(cfg_reg.origin_x);
            REG_ORIGIN_Y:     prdata = CFG_DATA_BITS'(cfg_reg.origin_y);
            REG_MAX_DISTANCE: prdata = CFG_DATA_BITS'(cfg_reg.max_distance);
            REG_DIR_EPSILON:  prdata = CFG_DATA_BITS'(cfg_reg.dir_epsilon);
            default:          prdata = '0;
        endcase
    end

    rbn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    rbn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tvalid = res_valid;
    assign m_tuser  = res.hit_found;
    assign m_tdata  = OUT_DATA_BITS'({res.hit_distance, res.hit_owner, res.end_y, res.end_x});

endmodule
